### hdl/hlrm_pkg.sv
package hlrm_pkg;

    localparam int MAX_EXPOSURES = 4;
    localparam int PIXEL_LEVELS  = 256;
    localparam int CHANNELS      = 3;
    localparam int PIXEL_FIELDS  = 4;

    localparam int LANES     = (PIXEL_FIELDS < MAX_EXPOSURES) ? PIXEL_FIELDS : MAX_EXPOSURES;
    localparam int BANKS     = (LANES + 1) / 2;
    localparam int TBL_DEPTH = CHANNELS * PIXEL_LEVELS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    localparam int VAL_W  = 16;
    localparam int TERM_W = VAL_W + 1;
    localparam int SUM_W  = TERM_W + $clog2(LANES);
    localparam int MAG_W  = SUM_W - 1;
    localparam int CNT_W  = $clog2(LANES + 1);

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] NUM_EXP_RST  = 3'd4;
    localparam logic [7:0] LOW_CUT_RST  = 8'd10;
    localparam logic [7:0] HIGH_CUT_RST = 8'd245;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_MERGE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_NUM_EXP  = 3'd0,
        REG_LOW_CUT  = 3'd1,
        REG_HIGH_CUT = 3'd2,
        REG_LOG_EXP0 = 3'd3,
        REG_LOG_EXP1 = 3'd4,
        REG_LOG_EXP2 = 3'd5,
        REG_LOG_EXP3 = 3'd6
    } t_reg;

    typedef struct packed {
        logic [2:0]                         num_exp;
        logic [7:0]                         low_cut;
        logic [7:0]                         high_cut;
        logic [PIXEL_FIELDS-1:0][VAL_W-1:0] log_exp;
    } t_cfg;

endpackage

### hdl/hlrm_if.sv
interface hlrm_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [1:0]  channel;
    logic [7:0]  entry_index;
    logic [15:0] entry_value;
    logic [7:0]  pixel_0;
    logic [7:0]  pixel_1;
    logic [7:0]  pixel_2;
    logic [7:0]  pixel_3;

    modport source (
        output valid, operation, channel, entry_index, entry_value,
               pixel_0, pixel_1, pixel_2, pixel_3,
        input  ready
    );
    modport sink (
        input  valid, operation, channel, entry_index, entry_value,
               pixel_0, pixel_1, pixel_2, pixel_3,
        output ready
    );
endinterface

interface hlrm_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] log_radiance;
    logic [2:0]  usable_count;
    logic        no_usable_sample;

    modport source (
        output valid, log_radiance, usable_count, no_usable_sample,
        input  ready
    );
    modport sink (
        input  valid, log_radiance, usable_count, no_usable_sample,
        output ready
    );
endinterface

### hdl/hlrm_ram.sv
module hlrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

### hdl/hlrm_cfg.sv
module hlrm_cfg import hlrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    t_reg w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = t_reg'(paddr[APB_AW-1:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_exp  <= NUM_EXP_RST;
            r_cfg.low_cut  <= LOW_CUT_RST;
            r_cfg.high_cut <= HIGH_CUT_RST;
            r_cfg.log_exp  <= '0;
        end else if (w_wr) begin
            case (w_reg)
                REG_NUM_EXP:  r_cfg.num_exp    <= pwdata[2:0];
                REG_LOW_CUT:  r_cfg.low_cut    <= pwdata[7:0];
                REG_HIGH_CUT: r_cfg.high_cut   <= pwdata[7:0];
                REG_LOG_EXP0: r_cfg.log_exp[0] <= pwdata[VAL_W-1:0];
                REG_LOG_EXP1: r_cfg.log_exp[1] <= pwdata[VAL_W-1:0];
                REG_LOG_EXP2: r_cfg.log_exp[2] <= pwdata[VAL_W-1:0];
                REG_LOG_EXP3: r_cfg.log_exp[3] <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_NUM_EXP:  prdata = APB_DW'(r_cfg.num_exp);
            REG_LOW_CUT:  prdata = APB_DW'(r_cfg.low_cut);
            REG_HIGH_CUT: prdata = APB_DW'(r_cfg.high_cut);
            REG_LOG_EXP0: prdata = APB_DW'(r_cfg.log_exp[0]);
            REG_LOG_EXP1: prdata = APB_DW'(r_cfg.log_exp[1]);
            REG_LOG_EXP2: prdata = APB_DW'(r_cfg.log_exp[2]);
            REG_LOG_EXP3: prdata = APB_DW'(r_cfg.log_exp[3]);
            default:      prdata = '0;
        endcase
    end

endmodule

### hdl/hlrm_div.sv
module hlrm_div import hlrm_pkg::*; (
    input  logic [MAG_W-1:0]         i_mag,
    input  logic                     i_neg,
    input  logic [CNT_W-1:0]         i_cnt,
    output logic signed [TERM_W-1:0] o_quot
);

    localparam int RCP_K  = MAG_W + $clog2(LANES);
    localparam int RCP_W  = RCP_K + 1;
    localparam int PROD_W = MAG_W + RCP_W;

    logic [RCP_W-1:0]  w_rcp [LANES+1];
    logic [PROD_W-1:0] w_prod;
    logic [MAG_W-1:0]  w_q;

    assign w_rcp[0] = '0;

    for (genvar d = 1; d <= LANES; d++) begin : g_rcp
        localparam logic [RCP_W-1:0] RD = RCP_W'(((64'd1 << RCP_K) + 64'(d) - 64'd1) / 64'(d));
        assign w_rcp[d] = RD;
    end

    assign w_prod = PROD_W'(i_mag) * PROD_W'(w_rcp[i_cnt]);
    assign w_q    = w_prod[RCP_K +: MAG_W];
    assign o_quot = i_neg ? -$signed(TERM_W'(w_q)) : $signed(TERM_W'(w_q));

endmodule

### hdl/hdr_log_radiance_merge.sv
// Pipeline: table-read stage, sum stage, output register. Throughput: one word
//   per cycle, loads and merges alike, when not stalled; four table reads per
//   merge come from two response-table copies with two read ports each.
// Stages advance independently, so input is taken while a result waits.
// Reset: synchronous, active low; clears control, resets config, not the table.
module hdr_log_radiance_merge import hlrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hlrm_in_if.sink           i_in,
    hlrm_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;

    logic             w_adv1;
    logic             w_adv2;
    logic             w_adv3;
    logic             w_acc;
    logic             w_merge;
    logic             w_we;
    logic [TBL_AW-1:0] w_waddr;
    logic [CNT_W-1:0] w_n_eff;
    logic             w_chok;
    logic [7:0]       w_pix  [PIXEL_FIELDS];
    logic [TBL_AW-1:0] w_addr [LANES];
    logic [LANES-1:0] w_use;
    logic [VAL_W-1:0] w_g    [2*BANKS];

    logic             r_s1_vld;
    logic [LANES-1:0] r_s1_use;
    logic             r_s1_chok;

    logic signed [TERM_W-1:0] w_term [LANES];
    logic signed [SUM_W-1:0]  w_sum;
    logic [CNT_W-1:0]         w_cnt;
    logic                     r_s2_vld;
    logic                     r_s2_neg;
    logic [MAG_W-1:0]         r_s2_mag;
    logic [CNT_W-1:0]         r_s2_cnt;

    logic signed [TERM_W-1:0] w_quot;
    logic                     r_o_vld;
    logic [TERM_W-1:0]        r_o_rad;
    logic [CNT_W-1:0]         r_o_cnt;

    hlrm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv3     = !r_o_vld || o_out.ready;
    assign w_adv2     = !r_s2_vld || w_adv3;
    assign w_adv1     = !r_s1_vld || w_adv2;
    assign i_in.ready = w_adv1;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_merge    = w_acc && (t_op'(i_in.operation) == OP_MERGE);

    assign w_pix[0] = i_in.pixel_0;
    assign w_pix[1] = i_in.pixel_1;
    assign w_pix[2] = i_in.pixel_2;
    assign w_pix[3] = i_in.pixel_3;

    assign w_chok   = int'(i_in.channel) < CHANNELS;
    assign w_n_eff  = (int'(w_cfg.num_exp) > LANES) ? CNT_W'(LANES) : CNT_W'(w_cfg.num_exp);
    assign w_waddr  = TBL_AW'(int'(i_in.channel) * PIXEL_LEVELS + int'(i_in.entry_index));
    assign w_we     = w_acc && (t_op'(i_in.operation) == OP_LOAD) && w_chok
                      && (int'(i_in.entry_index) < PIXEL_LEVELS);

    for (genvar t = 0; t < LANES; t++) begin : g_lane
        assign w_addr[t] = TBL_AW'(int'(i_in.channel) * PIXEL_LEVELS + int'(w_pix[t]));
        assign w_use[t]  = (CNT_W'(t) < w_n_eff) && (w_pix[t] > w_cfg.low_cut)
                           && (w_pix[t] < w_cfg.high_cut) && (int'(w_pix[t]) < PIXEL_LEVELS);
    end

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [TBL_AW-1:0] w_rb;
        if (2 * b + 1 < LANES) begin : g_pair
            assign w_rb = w_addr[2*b+1];
        end else begin : g_single
            assign w_rb = w_addr[2*b];
        end
        hlrm_ram #(
            .WIDTH (VAL_W),
            .DEPTH (TBL_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (w_we),
            .i_waddr   (w_waddr),
            .i_wdata   (i_in.entry_value),
            .i_re      (w_merge),
            .i_raddr_a (w_addr[2*b]),
            .i_raddr_b (w_rb),
            .o_rdata_a (w_g[2*b]),
            .o_rdata_b (w_g[2*b+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv1) begin
            r_s1_vld <= w_merge;
        end
        if (w_merge) begin
            r_s1_use  <= w_use;
            r_s1_chok <= w_chok;
        end
    end

    always_comb begin
        w_sum = '0;
        for (int t = 0; t < LANES; t++) begin
            w_term[t] = '0;
            if (r_s1_use[t]) begin
                w_term[t] = (r_s1_chok ? TERM_W'($signed(w_g[t])) : TERM_W'(0))
                            - TERM_W'($signed(w_cfg.log_exp[t]));
            end
            w_sum = w_sum + SUM_W'(w_term[t]);
        end
        w_cnt = CNT_W'($countones(r_s1_use));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv2) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_adv2 && r_s1_vld) begin
            r_s2_neg <= w_sum[SUM_W-1];
            r_s2_mag <= w_sum[SUM_W-1] ? MAG_W'(-w_sum) : MAG_W'(w_sum);
            r_s2_cnt <= w_cnt;
        end
    end

    hlrm_div u_div (
        .i_mag  (r_s2_mag),
        .i_neg  (r_s2_neg),
        .i_cnt  (r_s2_cnt),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv3) begin
            r_o_vld <= r_s2_vld;
        end
        if (w_adv3 && r_s2_vld) begin
            r_o_rad <= w_quot;
            r_o_cnt <= r_s2_cnt;
        end
    end

    assign o_out.valid            = r_o_vld;
    assign o_out.log_radiance     = r_o_rad;
    assign o_out.usable_count     = 3'(r_o_cnt);
    assign o_out.no_usable_sample = (r_o_cnt == '0);

    a_merge_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_merge |=> r_s1_vld)
        else $error("accepted merge word did not enter the read stage");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && !w_adv2) |=> (r_s2_vld && $stable(r_s2_mag) && $stable(r_s2_cnt)))
        else $error("stalled sum stage lost its word");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_cnt == '0) |-> (r_o_rad == '0))
        else $error("result without usable sample is not zero");

    a_no_load_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_adv2) |=> r_s1_vld && $stable(r_s1_use))
        else $error("read stage changed while stalled");

endmodule
